>>> rtl/mlpq_pkg.sv
// Package for the multilevel priority FIFO: field widths, action and status
// codes, controller state encoding and default sizes.
// No dependencies.
`default_nettype none

package mlpq_pkg;

  localparam int ACTION_W = 2;
  localparam int LEVEL_W  = 3;
  localparam int DATA_W   = 16;
  localparam int STATUS_W = 2;

  localparam int LEVELS_DEF      = 8;
  localparam int LEVEL_DEPTH_DEF = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR    = 2'd0,
    ACT_PUSH     = 2'd1,
    ACT_POP      = 2'd2,
    ACT_PUSH_POP = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_PASS  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_PUSH,
    CS_POP_RD,
    CS_POP,
    CS_DATA,
    CS_DONE
  } ctrl_state_e;

endpackage

`default_nettype wire

>>> rtl/mlpq_if.sv
// Request and response channel interfaces of the multilevel priority FIFO.
// Depends on mlpq_pkg for field widths.
`default_nettype none

interface mlpq_req_if;
  logic                         valid;
  logic                         ready;
  logic [mlpq_pkg::ACTION_W-1:0] action;
  logic [mlpq_pkg::LEVEL_W-1:0]  level;
  logic [mlpq_pkg::DATA_W-1:0]   data_in;

  modport source (output valid, output action, output level, output data_in, input ready);
  modport sink   (input valid, input action, input level, input data_in, output ready);
endinterface

interface mlpq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [mlpq_pkg::STATUS_W-1:0] status;
  logic [mlpq_pkg::DATA_W-1:0]   data_out;

  modport source (output valid, output status, output data_out, input ready);
  modport sink   (input valid, input status, input data_out, output ready);
endinterface

`default_nettype wire

>>> rtl/mlpq_entry_ram.sv
// Entry store: one synchronous memory holding all levels' FIFO slots,
// one write and one registered read per cycle. Depends on mlpq_pkg.
`default_nettype none

module mlpq_entry_ram #(
  parameter int DEPTH = mlpq_pkg::LEVELS_DEF * mlpq_pkg::LEVEL_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [mlpq_pkg::DATA_W-1:0] wdata_i,
  input  wire logic                        re_i,
  input  wire logic [AW-1:0]               raddr_i,
  output      logic [mlpq_pkg::DATA_W-1:0] rdata_o
);

  logic [mlpq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [mlpq_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/mlpq_ptr_ram.sv
// Pointer store: {head, tail} per level in a synchronous memory with a
// registered read. Per-level valid bits make unwritten or cleared levels
// read as zero pointers. Depends on mlpq_pkg.
`default_nettype none

module mlpq_ptr_ram #(
  parameter int LEVELS = mlpq_pkg::LEVELS_DEF,
  parameter int PW     = 4,
  parameter int LIW    = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            clr_i,
  input  wire logic            we_i,
  input  wire logic [LIW-1:0]  waddr_i,
  input  wire logic [2*PW-1:0] wdata_i,
  input  wire logic            re_i,
  input  wire logic [LIW-1:0]  raddr_i,
  output      logic [2*PW-1:0] rdata_o
);

  logic [2*PW-1:0] mem [LEVELS];
  logic [2*PW-1:0] rdata_q;
  logic [LEVELS-1:0] vld_q;
  logic rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  // never-written levels read as head = tail = 0
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

>>> rtl/mlpq_ctrl.sv
// Controller: nonempty bitmap, priority encoder, sequencer that reads,
// updates and writes back the pointer and entry stores, and the output
// register. Depends on mlpq_pkg and mlpq_if.
`default_nettype none

module mlpq_ctrl #(
  parameter int LEVELS      = mlpq_pkg::LEVELS_DEF,
  parameter int LEVEL_DEPTH = mlpq_pkg::LEVEL_DEPTH_DEF,
  parameter int PW          = $clog2(LEVEL_DEPTH),
  parameter int LIW         = (LEVELS > 1) ? $clog2(LEVELS) : 1,
  parameter int AW          = $clog2(LEVELS * LEVEL_DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  mlpq_req_if.sink                         req_i,
  mlpq_rsp_if.source                       rsp_o,
  // pointer store
  output      logic                        ptr_clr_o,
  output      logic                        ptr_we_o,
  output      logic [LIW-1:0]              ptr_waddr_o,
  output      logic [2*PW-1:0]             ptr_wdata_o,
  output      logic                        ptr_re_o,
  output      logic [LIW-1:0]              ptr_raddr_o,
  input  wire logic [2*PW-1:0]             ptr_rdata_i,
  // entry store
  output      logic                        ent_we_o,
  output      logic [AW-1:0]               ent_waddr_o,
  output      logic [mlpq_pkg::DATA_W-1:0] ent_wdata_o,
  output      logic                        ent_re_o,
  output      logic [AW-1:0]               ent_raddr_o,
  input  wire logic [mlpq_pkg::DATA_W-1:0] ent_rdata_i
);

  localparam int CMP_W = 6;

  mlpq_pkg::ctrl_state_e state_q, state_d;
  mlpq_pkg::action_e     act_q, act_d, req_act;

  logic [LEVELS-1:0]           bitmap_q, bitmap_d;
  logic [LIW-1:0]              lv_q, lv_d;
  logic [LIW-1:0]              top_q, top_d, top_c;
  logic [mlpq_pkg::DATA_W-1:0] val_q, val_d;
  logic [mlpq_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [mlpq_pkg::DATA_W-1:0] res_data_q, res_data_d;
  logic                        out_valid_q, out_valid_d;
  logic [mlpq_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [mlpq_pkg::DATA_W-1:0] out_data_q, out_data_d;

  logic [CMP_W-1:0] lvl_ext, top_ext;
  logic             in_range;
  logic [PW-1:0]    rd_head, rd_tail, head_nxt, tail_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(LEVEL_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // most urgent nonempty level
  always_comb begin
    top_c = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (bitmap_q[i]) begin
        top_c = LIW'(i);
      end
    end
  end

  assign req_act  = mlpq_pkg::action_e'(req_i.action);
  assign lvl_ext  = CMP_W'(req_i.level);
  assign top_ext  = CMP_W'(top_c);
  assign in_range = lvl_ext < CMP_W'(LEVELS);

  assign rd_head  = ptr_rdata_i[2*PW-1:PW];
  assign rd_tail  = ptr_rdata_i[PW-1:0];
  assign head_nxt = ptr_inc(rd_head);
  assign tail_nxt = ptr_inc(rd_tail);

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    lv_d         = lv_q;
    top_d        = top_q;
    val_d        = val_q;
    bitmap_d     = bitmap_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;

    req_i.ready  = 1'b0;
    ptr_clr_o    = 1'b0;
    ptr_we_o     = 1'b0;
    ptr_waddr_o  = lv_q;
    ptr_wdata_o  = {rd_head, tail_nxt};
    ptr_re_o     = 1'b0;
    ptr_raddr_o  = LIW'(req_i.level);
    ent_we_o     = 1'b0;
    ent_waddr_o  = AW'(lv_q) * AW'(LEVEL_DEPTH) + AW'(rd_tail);
    ent_wdata_o  = val_q;
    ent_re_o     = 1'b0;
    ent_raddr_o  = AW'(top_q) * AW'(LEVEL_DEPTH) + AW'(rd_head);

    // drop the output once taken
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      mlpq_pkg::CS_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          act_d        = req_act;
          lv_d         = LIW'(req_i.level);
          top_d        = top_c;
          val_d        = req_i.data_in;
          res_data_d   = '0;
          res_status_d = mlpq_pkg::ST_OK;
          state_d      = mlpq_pkg::CS_DONE;
          case (req_act)
            mlpq_pkg::ACT_CLEAR: begin
              ptr_clr_o = 1'b1;
              bitmap_d  = '0;
            end
            mlpq_pkg::ACT_PUSH: begin
              if (!in_range) begin
                res_status_d = mlpq_pkg::ST_FULL;
              end else begin
                ptr_re_o = 1'b1;
                state_d  = mlpq_pkg::CS_PUSH;
              end
            end
            mlpq_pkg::ACT_POP: begin
              if (bitmap_q == '0) begin
                res_status_d = mlpq_pkg::ST_EMPTY;
              end else begin
                ptr_re_o    = 1'b1;
                ptr_raddr_o = top_c;
                state_d     = mlpq_pkg::CS_POP;
              end
            end
            default: begin
              if (bitmap_q == '0 || lvl_ext < top_ext) begin
                res_status_d = mlpq_pkg::ST_PASS;
                res_data_d   = req_i.data_in;
              end else if (!in_range) begin
                res_status_d = mlpq_pkg::ST_FULL;
              end else begin
                ptr_re_o = 1'b1;
                state_d  = mlpq_pkg::CS_PUSH;
              end
            end
          endcase
        end
      end

      mlpq_pkg::CS_PUSH: begin
        if (bitmap_q[lv_q] && rd_head == rd_tail) begin
          res_status_d = mlpq_pkg::ST_FULL;
          state_d      = mlpq_pkg::CS_DONE;
        end else begin
          ent_we_o       = 1'b1;
          ptr_we_o       = 1'b1;
          bitmap_d[lv_q] = 1'b1;
          if (act_q == mlpq_pkg::ACT_PUSH) begin
            state_d = mlpq_pkg::CS_DONE;
          end else begin
            state_d = mlpq_pkg::CS_POP_RD;
          end
        end
      end

      mlpq_pkg::CS_POP_RD: begin
        // pointer write of the push lands first, then fetch the pop level
        ptr_re_o    = 1'b1;
        ptr_raddr_o = top_q;
        state_d     = mlpq_pkg::CS_POP;
      end

      mlpq_pkg::CS_POP: begin
        ent_re_o    = 1'b1;
        ptr_we_o    = 1'b1;
        ptr_waddr_o = top_q;
        ptr_wdata_o = {head_nxt, rd_tail};
        if (head_nxt == rd_tail) begin
          bitmap_d[top_q] = 1'b0;
        end
        state_d = mlpq_pkg::CS_DATA;
      end

      mlpq_pkg::CS_DATA: begin
        res_status_d = mlpq_pkg::ST_OK;
        res_data_d   = ent_rdata_i;
        state_d      = mlpq_pkg::CS_DONE;
      end

      mlpq_pkg::CS_DONE: begin
        // hold until the output register frees up
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_data_d   = res_data_q;
          state_d      = mlpq_pkg::CS_IDLE;
        end
      end

      default: begin
        state_d = mlpq_pkg::CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlpq_pkg::CS_IDLE;
      bitmap_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bitmap_q    <= bitmap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    lv_q         <= lv_d;
    top_q        <= top_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.status   = out_status_q;
  assign rsp_o.data_out = out_data_q;

endmodule

`default_nettype wire

>>> rtl/multilevel_priority_fifo_top.sv
// Multilevel priority FIFO. Clear and answers decided from the bitmap go straight
// to the response stage; push reads the pointer store first, pop also reads the
// entry store, and a push-pop that moves data does the push and then the pop.
// A new request is taken once the sequencer is back in idle, so the block takes no
// new request while the pointer and entry memory accesses of the last are under way.
// Reset empties every level; entry contents are kept. Needs mlpq_pkg, mlpq_if.
`default_nettype none

module multilevel_priority_fifo_top #(
  parameter int LEVELS      = mlpq_pkg::LEVELS_DEF,
  parameter int LEVEL_DEPTH = mlpq_pkg::LEVEL_DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mlpq_req_if.sink   req_i,
  mlpq_rsp_if.source rsp_o
);

  localparam int PW    = $clog2(LEVEL_DEPTH);
  localparam int LIW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int DEPTH = LEVELS * LEVEL_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  logic                        ptr_clr, ptr_we, ptr_re;
  logic [LIW-1:0]              ptr_waddr, ptr_raddr;
  logic [2*PW-1:0]             ptr_wdata, ptr_rdata;
  logic                        ent_we, ent_re;
  logic [AW-1:0]               ent_waddr, ent_raddr;
  logic [mlpq_pkg::DATA_W-1:0] ent_wdata, ent_rdata;

  mlpq_ctrl #(
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .PW          (PW),
    .LIW         (LIW),
    .AW          (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .ptr_clr_o   (ptr_clr),
    .ptr_we_o    (ptr_we),
    .ptr_waddr_o (ptr_waddr),
    .ptr_wdata_o (ptr_wdata),
    .ptr_re_o    (ptr_re),
    .ptr_raddr_o (ptr_raddr),
    .ptr_rdata_i (ptr_rdata),
    .ent_we_o    (ent_we),
    .ent_waddr_o (ent_waddr),
    .ent_wdata_o (ent_wdata),
    .ent_re_o    (ent_re),
    .ent_raddr_o (ent_raddr),
    .ent_rdata_i (ent_rdata)
  );

  mlpq_ptr_ram #(
    .LEVELS (LEVELS),
    .PW     (PW),
    .LIW    (LIW)
  ) u_ptr_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (ptr_clr),
    .we_i    (ptr_we),
    .waddr_i (ptr_waddr),
    .wdata_i (ptr_wdata),
    .re_i    (ptr_re),
    .raddr_i (ptr_raddr),
    .rdata_o (ptr_rdata)
  );

  mlpq_entry_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

endmodule

`default_nettype wire

>>> bench/multilevel_priority_fifo_top_tb.sv
// Testbench for multilevel_priority_fifo_top: directed and random requests with
// random idling on both channels, checked against an in-bench predictor.
// Depends on mlpq_pkg, mlpq_if and the RTL of the block.
`timescale 1ns / 1ps

module multilevel_priority_fifo_top_tb;
  import mlpq_pkg::*;

  localparam int NUM_LEVELS = LEVELS_DEF;
  localparam int DEPTH      = LEVEL_DEPTH_DEF;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int RAND_ITEMS = 850;
  localparam int NUM_PHASES = 4;

  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] data;
  } answer_t;

  // Tracks the queue contents and the answers still owed by the block.
  class PrioQueueScoreboard;
    answer_t             pending_answers[$];
    logic [DATA_W-1:0]   entry_store[NUM_LEVELS*DEPTH];
    logic [PTR_W-1:0]    head_ptr[NUM_LEVELS];
    logic [PTR_W-1:0]    tail_ptr[NUM_LEVELS];
    logic [NUM_LEVELS-1:0] nonempty;
    int                  mismatch_count;

    function new();
      foreach (entry_store[i]) entry_store[i] = '0;
      clear_levels();
      mismatch_count = 0;
    endfunction

    function void clear_levels();
      foreach (head_ptr[i]) begin
        head_ptr[i] = '0;
        tail_ptr[i] = '0;
      end
      nonempty = '0;
    endfunction

    function int top_level();
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (nonempty[l]) return l;
      end
      return NUM_LEVELS;
    endfunction

    function bit level_full(int lv);
      if (lv >= NUM_LEVELS) return 1'b1;
      return nonempty[lv] && (tail_ptr[lv] == head_ptr[lv]);
    endfunction

    function void push_entry(int lv, logic [DATA_W-1:0] v);
      entry_store[lv*DEPTH + tail_ptr[lv]] = v;
      tail_ptr[lv] = tail_ptr[lv] + 1'b1;
      nonempty[lv] = 1'b1;
    endfunction

    function logic [DATA_W-1:0] pop_entry(int lv);
      logic [DATA_W-1:0] v;
      v = entry_store[lv*DEPTH + head_ptr[lv]];
      head_ptr[lv] = head_ptr[lv] + 1'b1;
      if (head_ptr[lv] == tail_ptr[lv]) nonempty[lv] = 1'b0;
      return v;
    endfunction

    function void note_request(action_e act, logic [LEVEL_W-1:0] lv, logic [DATA_W-1:0] v);
      answer_t ans;
      int      top;
      ans.status = ST_OK;
      ans.data   = '0;
      case (act)
        ACT_CLEAR: clear_levels();
        ACT_PUSH: begin
          if (level_full(lv)) ans.status = ST_FULL;
          else push_entry(lv, v);
        end
        ACT_POP: begin
          if (nonempty == '0) ans.status = ST_EMPTY;
          else ans.data = pop_entry(top_level());
        end
        default: begin
          top = top_level();
          if (nonempty == '0 || int'(lv) < top) begin
            ans.status = ST_PASS;
            ans.data   = v;
          end else if (level_full(lv)) begin
            ans.status = ST_FULL;
          end else begin
            // pop from the level that led before this push
            push_entry(lv, v);
            ans.data = pop_entry(top);
          end
        end
      endcase
      pending_answers.push_back(ans);
    endfunction

    task flag_mismatch(string what);
      $display("%0t mismatch: %s", $time, what);
      mismatch_count++;
    endtask

    task check_response(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] d);
      answer_t ans;
      if (pending_answers.size() == 0) begin
        flag_mismatch($sformatf("unexpected response status %0d data %h", st, d));
      end else begin
        ans = pending_answers.pop_front();
        if (st !== ans.status)
          flag_mismatch($sformatf("status %0d, want %s", st, ans.status.name()));
        if (d !== ans.data)
          flag_mismatch($sformatf("data_out %h, want %h", d, ans.data));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_stall_pct;

  PrioQueueScoreboard sb;

  mlpq_req_if req ();
  mlpq_rsp_if rsp ();

  multilevel_priority_fifo_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always #5 clk_i = ~clk_i;

  // Sample pre-edge values, then pick the next ready.
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) sb.check_response(rsp.status, rsp.data_out);
    rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_req(action_e act, logic [LEVEL_W-1:0] lv, logic [DATA_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid   <= 1'b1;
    req.action  <= act;
    req.level   <= lv;
    req.data_in <= v;
    do @(posedge clk_i); while (!req.ready);
    sb.note_request(act, lv, v);
  endtask

  task automatic run_directed();
    send_req(ACT_CLEAR, 3'd0, 16'h0000);
    send_req(ACT_POP, 3'd0, 16'h0000);        // pop with nothing queued
    send_req(ACT_PUSH_POP, 3'd7, 16'hffff);   // empty queue: pass through
    send_req(ACT_PUSH, 3'd7, 16'hffff);
    send_req(ACT_PUSH_POP, 3'd3, 16'h1234);   // more urgent than every queued level
    send_req(ACT_PUSH, 3'd0, 16'h0000);
    send_req(ACT_PUSH_POP, 3'd0, 16'haaaa);   // same level as the top: push then pop
    send_req(ACT_POP, 3'd0, 16'h0000);
    send_req(ACT_POP, 3'd0, 16'h0000);
    for (int i = 0; i < DEPTH; i++) send_req(ACT_PUSH, 3'd2, 16'h5555 ^ (16'(i) << 4));
    send_req(ACT_PUSH, 3'd2, 16'h7777);       // level full
    send_req(ACT_PUSH_POP, 3'd2, 16'h8888);   // full level at the top
    send_req(ACT_PUSH_POP, 3'd4, 16'h4321);   // push lower level, pop the top
    send_req(ACT_CLEAR, 3'd5, 16'hffff);
  endtask

  task automatic run_random(int count);
    int push_w, pop_w, clear_w, lvl_hi, r, pick;
    logic [DATA_W-1:0] v;
    action_e act;
    push_w = 40; pop_w = 30; clear_w = 1; lvl_hi = 7;
    for (int n = 0; n < count; n++) begin
      // reshape the mix every few dozen requests
      if (n % 40 == 0) begin
        push_w  = $urandom_range(25, 60);
        pop_w   = $urandom_range(15, 40);
        clear_w = $urandom_range(0, 2);
        pick    = $urandom_range(2);
        lvl_hi  = (pick == 0) ? 1 : (pick == 1) ? 3 : 7;
      end
      r = $urandom_range(99);
      if (r < clear_w) act = ACT_CLEAR;
      else if (r < clear_w + push_w) act = ACT_PUSH;
      else if (r < clear_w + push_w + pop_w) act = ACT_POP;
      else act = ACT_PUSH_POP;
      pick = $urandom_range(15);
      if (pick == 0) v = '0;
      else if (pick == 1) v = '1;
      else v = DATA_W'($urandom);
      send_req(act, LEVEL_W'($urandom_range(lvl_hi)), v);
    end
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    req.valid      = 1'b0;
    req.action     = ACT_CLEAR;
    req.level      = '0;
    req.data_in    = '0;
    rsp.ready      = 1'b0;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      if (ph == 0) run_directed();
      run_random(RAND_ITEMS / NUM_PHASES);
    end
    req.valid <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("PASS multilevel_priority_fifo_top");
    end else begin
      $display("FAIL multilevel_priority_fifo_top");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL multilevel_priority_fifo_top");
    $finish;
  end

endmodule
